[hdl/rhd_pkg.sv]
package rhd_pkg;

    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SQRT_STAGES = 15;
    localparam int RAD_W       = 2 * SQRT_STAGES;
    localparam int QUO_BITS    = 16;
    localparam int NUM_W       = 2 * QUO_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_TOOL_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOOL_Z     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOOL_DEPTH = 2'd2;

endpackage

[hdl/rhd_isqrt.sv]
// Integer square root, one root bit per pipeline stage.
module rhd_isqrt
    import rhd_pkg::*;
#(
    parameter int PAY_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [RAD_W-1:0]       in_rad,
    input  logic [PAY_W-1:0]       in_pay,
    output logic                   out_valid,
    output logic [SQRT_STAGES-1:0] out_root,
    output logic [PAY_W-1:0]       out_pay
);

    logic                   v_reg    [SQRT_STAGES];
    logic [RAD_W-1:0]       n_reg    [SQRT_STAGES];
    logic [SQRT_STAGES+1:0] rem_reg  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] root_reg [SQRT_STAGES];
    logic [PAY_W-1:0]       pay_reg  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        logic                   v_in;
        logic [RAD_W-1:0]       n_in;
        logic [SQRT_STAGES+1:0] rem_in;
        logic [SQRT_STAGES-1:0] root_in;
        logic [PAY_W-1:0]       pay_in;
        logic [SQRT_STAGES+1:0] rem_sh;
        logic [SQRT_STAGES+1:0] trial;
        logic                   ge;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign n_in    = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign n_in    = n_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign pay_in  = pay_reg[s-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        assign rem_sh = {rem_in[SQRT_STAGES-1:0], n_in[2*(SQRT_STAGES-1-s)+1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s]    <= n_in;
                rem_reg[s]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[s] <= {root_in[SQRT_STAGES-2:0], ge};
                pay_reg[s]  <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_pay   = pay_reg[SQRT_STAGES-1];

endmodule

[hdl/rhd_div.sv]
// Restoring divider, one quotient bit per pipeline stage.
// The upper half of the numerator must be below the divisor.
module rhd_div
    import rhd_pkg::*;
#(
    parameter int PAY_W = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    in_num,
    input  logic [QUO_BITS-1:0] in_den,
    input  logic [PAY_W-1:0]    in_pay,
    output logic                out_valid,
    output logic [QUO_BITS-1:0] out_quo,
    output logic [PAY_W-1:0]    out_pay
);

    logic                v_reg   [QUO_BITS];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS];
    logic [QUO_BITS-1:0] den_reg [QUO_BITS];
    logic [QUO_BITS-1:0] rem_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];
    logic [PAY_W-1:0]    pay_reg [QUO_BITS];

    for (genvar s = 0; s < QUO_BITS; s++)
    begin : g_stage
        logic                v_in;
        logic [QUO_BITS-1:0] low_in;
        logic [QUO_BITS-1:0] den_in;
        logic [QUO_BITS-1:0] rem_in;
        logic [QUO_BITS-1:0] quo_in;
        logic [PAY_W-1:0]    pay_in;
        logic [QUO_BITS:0]   rem_sh;
        logic [QUO_BITS:0]   rem_sub;
        logic                ge;

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign low_in = in_num[QUO_BITS-1:0];
            assign den_in = in_den;
            assign rem_in = in_num[NUM_W-1:QUO_BITS];
            assign quo_in = '0;
            assign pay_in = in_pay;
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign low_in = low_reg[s-1];
            assign den_in = den_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign pay_in = pay_reg[s-1];
        end

        assign rem_sh  = {rem_in, low_in[QUO_BITS-1-s]};
        assign rem_sub = rem_sh - {1'b0, den_in};
        assign ge      = (rem_sh >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[s] <= low_in;
                den_reg[s] <= den_in;
                rem_reg[s] <= ge ? rem_sub[QUO_BITS-1:0] : rem_sh[QUO_BITS-1:0];
                quo_reg[s] <= {quo_in[QUO_BITS-2:0], ge};
                pay_reg[s] <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[QUO_BITS-1];
    assign out_quo   = quo_reg[QUO_BITS-1];
    assign out_pay   = pay_reg[QUO_BITS-1];

endmodule

[hdl/radial_heightfield_dent_core.sv]
// Crater press for a heightfield mesh. Each input word carries one vertex (x, z, height,
// all signed Q5.11) and each output word carries its new height and a flag that is set
// when the height was replaced by the crater surface. The crater sits at the configured
// tool point; its radius is minus the tool depth, so a tool at or above ground changes
// nothing. The block is a fully pipelined datapath that takes one vertex every clock
// cycle while the output is not stalled. There are 37 register stages: the 15-stage
// square-root pipeline (one root bit per stage) and the 16-stage divider pipeline (one
// quotient bit per stage) plus six arithmetic stages around them. The whole pipeline
// advances together; when the output word is held by the consumer, every stage holds
// and the input is not ready.
// Tool registers should be written only while no vertex is in flight.
module radial_heightfield_dent_core
    import rhd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // Vertex input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // vert_x [15:0], vert_z [31:16], vert_height [47:32]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // new_height [15:0]
    output logic                 m_tuser    // was_lowered [0]
);

    localparam int SQ_PAY_W  = DATA_W + 2 + DATA_W + RAD_W;
    localparam int DIV_PAY_W = DATA_W + 2 + DATA_W;

    // Tool configuration registers.
    logic [DATA_W-1:0] tool_x_reg;
    logic [DATA_W-1:0] tool_z_reg;
    logic [DATA_W-1:0] tool_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_x_reg     <= '0;
            tool_z_reg     <= '0;
            tool_depth_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TOOL_X:     tool_x_reg     <= cfg_data;
                REG_TOOL_Z:     tool_z_reg     <= cfg_data;
                REG_TOOL_DEPTH: tool_depth_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The pipeline moves as one: it advances whenever the output register is
    // empty or its word is being taken.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: offsets from the tool point and the crater radius.
    logic              s1_v_reg;
    logic [16:0]       s1_dx_reg;
    logic [16:0]       s1_dz_reg;
    logic [DATA_W-1:0] s1_old_reg;
    logic [DATA_W-1:0] s1_r_reg;
    logic              s1_neg_reg;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vz;

    assign vx = s_tdata[15:0];
    assign vz = s_tdata[31:16];

    // Stage 2: squares of the offsets and of the radius.
    logic              s2_v_reg;
    logic [31:0]       s2_sqx_reg;
    logic [31:0]       s2_sqz_reg;
    logic [30:0]       s2_r2_reg;
    logic [DATA_W-1:0] s2_old_reg;
    logic [DATA_W-1:0] s2_r_reg;
    logic              s2_neg_reg;
    logic [33:0]       sqx_full;
    logic [33:0]       sqz_full;
    logic [31:0]       r2_full;

    assign sqx_full = 34'($signed(s1_dx_reg) * $signed(s1_dx_reg));
    assign sqz_full = 34'($signed(s1_dz_reg) * $signed(s1_dz_reg));
    assign r2_full  = s1_r_reg * s1_r_reg;

    // Stage 3: squared distance and the zone tests.
    logic              s3_v_reg;
    logic [RAD_W-1:0]  s3_d_reg;
    logic              s3_inside_reg;
    logic              s3_inner_reg;
    logic [DATA_W-1:0] s3_old_reg;
    logic [DATA_W-1:0] s3_r_reg;
    logic [32:0]       dsum;

    assign dsum = {1'b0, s2_sqx_reg} + {1'b0, s2_sqz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_tvalid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= {vx[15], vx} - {tool_x_reg[15], tool_x_reg};
            s1_dz_reg  <= {vz[15], vz} - {tool_z_reg[15], tool_z_reg};
            s1_old_reg <= s_tdata[47:32];
            s1_r_reg   <= -tool_depth_reg;
            s1_neg_reg <= tool_depth_reg[15];

            s2_sqx_reg <= sqx_full[31:0];
            s2_sqz_reg <= sqz_full[31:0];
            s2_r2_reg  <= r2_full[30:0];
            s2_old_reg <= s1_old_reg;
            s2_r_reg   <= s1_r_reg;
            s2_neg_reg <= s1_neg_reg;

            // Inside when d < r, inner zone when d < r/2, both tested on squares.
            s3_d_reg      <= dsum[RAD_W-1:0];
            s3_inside_reg <= s2_neg_reg && (dsum < {2'b00, s2_r2_reg});
            s3_inner_reg  <= ({dsum, 2'b00} < {4'b0000, s2_r2_reg});
            s3_old_reg    <= s2_old_reg;
            s3_r_reg      <= s2_r_reg;
        end
    end

    // Square root of the squared distance, needed by the outer zone.
    logic                   sq_v;
    logic [SQRT_STAGES-1:0] sq_root;
    logic [SQ_PAY_W-1:0]    sq_pay;
    logic [DATA_W-1:0]      sq_old;
    logic                   sq_inside;
    logic                   sq_inner;
    logic [DATA_W-1:0]      sq_r;
    logic [RAD_W-1:0]       sq_d;

    rhd_isqrt #(
        .PAY_W (SQ_PAY_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .in_rad    (s3_d_reg),
        .in_pay    ({s3_old_reg, s3_inside_reg, s3_inner_reg, s3_r_reg, s3_d_reg}),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_pay   (sq_pay)
    );

    assign {sq_old, sq_inside, sq_inner, sq_r, sq_d} = sq_pay;

    // Stage 4: distance left to the rim.
    logic              s4_v_reg;
    logic [DATA_W-1:0] s4_gap_reg;
    logic [DATA_W-1:0] s4_old_reg;
    logic              s4_inside_reg;
    logic              s4_inner_reg;
    logic [DATA_W-1:0] s4_r_reg;
    logic [RAD_W-1:0]  s4_d_reg;

    // Stage 5: dividend for either zone.
    logic              s5_v_reg;
    logic [NUM_W-1:0]  s5_num_reg;
    logic [DATA_W-1:0] s5_r_reg;
    logic [DATA_W-1:0] s5_old_reg;
    logic              s5_inside_reg;
    logic              s5_inner_reg;
    logic [31:0]       gap_sq;

    assign gap_sq = s4_gap_reg * s4_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= sq_v;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_gap_reg    <= sq_r - {1'b0, sq_root};
            s4_old_reg    <= sq_old;
            s4_inside_reg <= sq_inside;
            s4_inner_reg  <= sq_inner;
            s4_r_reg      <= sq_r;
            s4_d_reg      <= sq_d;

            // Inner zone divides 2*D by r, outer zone divides 2*gap^2 by r.
            s5_num_reg    <= s4_inner_reg ? {1'b0, s4_d_reg, 1'b0} : {gap_sq[30:0], 1'b0};
            s5_r_reg      <= s4_r_reg;
            s5_old_reg    <= s4_old_reg;
            s5_inside_reg <= s4_inside_reg;
            s5_inner_reg  <= s4_inner_reg;
        end
    end

    logic                 dv_v;
    logic [QUO_BITS-1:0]  dv_quo;
    logic [DIV_PAY_W-1:0] dv_pay;
    logic [DATA_W-1:0]    dv_old;
    logic                 dv_inside;
    logic                 dv_inner;
    logic [DATA_W-1:0]    dv_r;

    rhd_div #(
        .PAY_W (DIV_PAY_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_num    (s5_num_reg),
        .in_den    (s5_r_reg),
        .in_pay    ({s5_old_reg, s5_inside_reg, s5_inner_reg, s5_r_reg}),
        .out_valid (dv_v),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    assign {dv_old, dv_inside, dv_inner, dv_r} = dv_pay;

    // Final stage: crater target, compared with the old height.
    logic [16:0] target;
    logic        lower;
    logic [15:0] new_height_reg;
    logic        was_lowered_reg;

    assign target = dv_inner ? ({1'b0, dv_quo} - {1'b0, dv_r}) : (17'd0 - {1'b0, dv_quo});
    assign lower  = dv_inside && ($signed(target) < $signed({dv_old[15], dv_old}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_height_reg  <= lower ? target[15:0] : dv_old;
            was_lowered_reg <= lower;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = new_height_reg;
    assign m_tuser  = was_lowered_reg;

    // A crater height never lies above ground.
    a_lowered_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata) <= 0)
        else $error("lowered height above ground");

    // Only a tool below ground can lower a vertex.
    a_lowered_needs_dent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> tool_depth_reg[15])
        else $error("vertex lowered by a tool at or above ground");

    // Held output word keeps the whole pipeline still.
    a_stall_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // Input is taken exactly when the pipeline advances.
    a_ready_follows_enable: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow pipeline advance");

endmodule
